// ===== sv/button_click_long_press_detector_assert.svh =====
// Assertion macros for the button detector checker.
// The including scope must provide clk and an active-high rst.
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define BCLD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button detector check failed");

// Consequent in the cycle after the antecedent.
`define BCLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button detector check failed");

`endif

// ===== sv/bcld_pkg.sv =====
// Shared types and constants for the button click and long-press detector.
// Used by the report channel interface, the top level and the checker.
`timescale 1ns / 1ps

package bcld_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int CFG_TIME_W = 16;
  localparam int EVENT_W    = 3;
  localparam int ENABLE_W   = 5;
  localparam int COUNT_W    = 3;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_SHORT    = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TRIPLE   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_HOLD     = 3'd4;
  localparam logic [EVENT_W-1:0] EV_LONG_END = 3'd5;

  // Bit positions within event_enable.
  localparam int EN_SINGLE   = 0;
  localparam int EN_DOUBLE   = 1;
  localparam int EN_TRIPLE   = 2;
  localparam int EN_HOLD     = 3;
  localparam int EN_LONG_END = 4;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_ACTIVE_LOW    = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [2:0] REG_CLICK_GAP     = 3'd2;
  localparam logic [2:0] REG_HOLD_LOCKOUT  = 3'd3;
  localparam logic [2:0] REG_CLICK_LOCKOUT = 3'd4;
  localparam logic [2:0] REG_EVENT_ENABLE  = 3'd5;

  localparam logic                  RST_ACTIVE_LOW    = 1'b1;
  localparam logic [CFG_TIME_W-1:0] RST_LONG_PRESS    = 16'd3000;
  localparam logic [CFG_TIME_W-1:0] RST_CLICK_GAP     = 16'd250;
  localparam logic [CFG_TIME_W-1:0] RST_HOLD_LOCKOUT  = 16'd100;
  localparam logic [CFG_TIME_W-1:0] RST_CLICK_LOCKOUT = 16'd250;
  localparam logic [ENABLE_W-1:0]   RST_EVENT_ENABLE  = 5'd31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef struct packed {
    logic [EVENT_W-1:0] event_code;
    logic               button_pressed;
  } result_t;

endpackage

// ===== sv/bcld_sample_if.sv =====
// Input channel of the button detector: one raw pin sample per request.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface bcld_sample_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

// ===== sv/bcld_report_if.sv =====
// Output channel of the button detector: one event report per sample.
// Depends on bcld_pkg for the event code width.
`timescale 1ns / 1ps

interface bcld_report_if;
  logic                             valid;
  logic                             ready;
  logic [bcld_pkg::EVENT_W-1:0]     event_code;
  logic                             button_pressed;

  modport source (output valid, output event_code, output button_pressed, input ready);
  modport sink (input valid, input event_code, input button_pressed, output ready);
endinterface

// ===== sv/button_click_long_press_detector.sv =====
// Button click and long-press detector.
// Each request on the sample channel is one time tick carrying the raw pin
// level. Every sample yields exactly one request on the report channel with
// the event code (none, single, double, triple click, long hold, long end)
// and the polarity-corrected pressed flag.
// Each report is registered in the report register, or in the skid register
// while one stalls. Throughput is one sample per cycle unless the skid is
// full; all per-tick logic is a single pass between the state registers and
// the report register. A two-entry output stage (report register plus skid
// register) lets one further sample be accepted while a report stalls; with
// both entries full, sample.ready drops until the receiver takes a report.
// The user must write configuration over the APB port only while no sample
// is in flight; the block does not enforce it. Registers sit at byte
// addresses 0, 4, 8, 12, 16 and 20. Synchronous reset clears the timing
// state and both output entries and restores the register defaults (active
// low, 3000, 250, 100, 250, all events enabled).
// Depends on bcld_pkg, bcld_sample_if and bcld_report_if.
`timescale 1ns / 1ps

module button_click_long_press_detector #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  bcld_sample_if.sink                         sample,
  bcld_report_if.source                       report,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcld_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bcld_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bcld_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CMP_W = (TIME_WIDTH > bcld_pkg::CFG_TIME_W) ? TIME_WIDTH
                                                             : bcld_pkg::CFG_TIME_W;

  // Configuration registers.
  logic                                active_low;
  logic [bcld_pkg::CFG_TIME_W-1:0]     long_press_ticks;
  logic [bcld_pkg::CFG_TIME_W-1:0]     click_gap_ticks;
  logic [bcld_pkg::CFG_TIME_W-1:0]     hold_lockout_ticks;
  logic [bcld_pkg::CFG_TIME_W-1:0]     click_lockout_ticks;
  logic [bcld_pkg::ENABLE_W-1:0]       event_enable;

  logic                                cfg_write;
  logic [2:0]                          cfg_index;

  // Detector state.
  bcld_pkg::phase_t                    phase, phase_next;
  logic [TIME_WIDTH-1:0]               elapsed, elapsed_next, elapsed_inc;
  logic [bcld_pkg::COUNT_W-1:0]        click_count, click_count_next;
  logic                                long_flag, long_flag_next;
  logic [bcld_pkg::CFG_TIME_W-1:0]     lockout, lockout_next;

  logic                                in_fire;
  logic                                pressed;
  logic                                evaluate;
  logic                                long_over;
  logic                                gap_over;
  logic                                confirm_fire;
  logic                                count_reportable;
  logic                                click_enabled;
  logic                                confirm_click;
  logic [bcld_pkg::EVENT_W-1:0]        event_code;

  // Output stage.
  bcld_pkg::result_t                   res_new, out_res, skid_res;
  logic                                out_valid, skid_valid;

  // ---------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_index = paddr[bcld_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low          <= bcld_pkg::RST_ACTIVE_LOW;
      long_press_ticks    <= bcld_pkg::RST_LONG_PRESS;
      click_gap_ticks     <= bcld_pkg::RST_CLICK_GAP;
      hold_lockout_ticks  <= bcld_pkg::RST_HOLD_LOCKOUT;
      click_lockout_ticks <= bcld_pkg::RST_CLICK_LOCKOUT;
      event_enable        <= bcld_pkg::RST_EVENT_ENABLE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcld_pkg::REG_ACTIVE_LOW:    active_low <= pwdata[0];
        bcld_pkg::REG_LONG_PRESS:    long_press_ticks <= pwdata[bcld_pkg::CFG_TIME_W-1:0];
        bcld_pkg::REG_CLICK_GAP:     click_gap_ticks <= pwdata[bcld_pkg::CFG_TIME_W-1:0];
        bcld_pkg::REG_HOLD_LOCKOUT:  hold_lockout_ticks <= pwdata[bcld_pkg::CFG_TIME_W-1:0];
        bcld_pkg::REG_CLICK_LOCKOUT: click_lockout_ticks <= pwdata[bcld_pkg::CFG_TIME_W-1:0];
        bcld_pkg::REG_EVENT_ENABLE:  event_enable <= pwdata[bcld_pkg::ENABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      bcld_pkg::REG_ACTIVE_LOW:    prdata = bcld_pkg::APB_DATA_W'(active_low);
      bcld_pkg::REG_LONG_PRESS:    prdata = bcld_pkg::APB_DATA_W'(long_press_ticks);
      bcld_pkg::REG_CLICK_GAP:     prdata = bcld_pkg::APB_DATA_W'(click_gap_ticks);
      bcld_pkg::REG_HOLD_LOCKOUT:  prdata = bcld_pkg::APB_DATA_W'(hold_lockout_ticks);
      bcld_pkg::REG_CLICK_LOCKOUT: prdata = bcld_pkg::APB_DATA_W'(click_lockout_ticks);
      bcld_pkg::REG_EVENT_ENABLE:  prdata = bcld_pkg::APB_DATA_W'(event_enable);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Per-tick evaluation
  // ---------------------------------------------------------------------
  assign sample.ready = !skid_valid;
  assign in_fire      = sample.valid && sample.ready;

  assign pressed     = sample.button_level ^ active_low;
  assign evaluate    = (lockout == '0);
  // The timer advances on every tick, lockout ticks included, and saturates.
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign long_over   = CMP_W'(elapsed_inc) > CMP_W'(long_press_ticks);
  assign gap_over    = CMP_W'(elapsed_inc) > CMP_W'(click_gap_ticks);

  assign confirm_fire = evaluate && !pressed && (phase == bcld_pkg::PH_SHORT) && gap_over;

  always_comb begin
    count_reportable = 1'b1;
    click_enabled    = 1'b0;
    case (click_count)
      3'd1:    click_enabled = event_enable[bcld_pkg::EN_SINGLE];
      3'd2:    click_enabled = event_enable[bcld_pkg::EN_DOUBLE];
      3'd3:    click_enabled = event_enable[bcld_pkg::EN_TRIPLE];
      default: count_reportable = 1'b0;
    endcase
  end

  assign confirm_click = confirm_fire && count_reportable;

  // Next-state logic.
  always_comb begin
    phase_next       = phase;
    elapsed_next     = elapsed_inc;
    click_count_next = click_count;
    long_flag_next   = long_flag;
    lockout_next     = evaluate ? lockout : lockout - 1'b1;

    if (evaluate) begin
      if (pressed) begin
        unique case (phase)
          bcld_pkg::PH_INACTIVE: begin
            elapsed_next     = '0;
            phase_next       = bcld_pkg::PH_PRESSED;
            click_count_next = '0;
          end
          bcld_pkg::PH_PRESSED: begin
            if (long_over) begin
              phase_next     = bcld_pkg::PH_LONG;
              long_flag_next = 1'b1;
            end
            // A short press still held pauses evaluation for a while.
            if (!long_over && !long_flag) begin
              lockout_next = hold_lockout_ticks;
            end
          end
          bcld_pkg::PH_SHORT: begin
            elapsed_next = '0;
            phase_next   = bcld_pkg::PH_PRESSED;
          end
          bcld_pkg::PH_LONG: ;
        endcase
      end else begin
        unique case (phase)
          bcld_pkg::PH_INACTIVE: ;
          bcld_pkg::PH_PRESSED: begin
            if (click_count != bcld_pkg::COUNT_MAX) begin
              click_count_next = click_count + 1'b1;
            end
            elapsed_next = '0;
            phase_next   = bcld_pkg::PH_SHORT;
          end
          bcld_pkg::PH_SHORT: begin
            if (gap_over) begin
              phase_next = bcld_pkg::PH_INACTIVE;
            end
          end
          bcld_pkg::PH_LONG: begin
            click_count_next = '0;
            long_flag_next   = 1'b0;
            phase_next       = bcld_pkg::PH_INACTIVE;
          end
        endcase
      end
    end

    if (confirm_click) begin
      click_count_next = '0;
      long_flag_next   = 1'b0;
      phase_next       = bcld_pkg::PH_INACTIVE;
      elapsed_next     = '0;
      lockout_next     = click_lockout_ticks;
    end
  end

  // Event selection; later conditions take priority.
  always_comb begin
    event_code = bcld_pkg::EV_NONE;
    if (evaluate && !pressed && (phase == bcld_pkg::PH_LONG) &&
        event_enable[bcld_pkg::EN_LONG_END]) begin
      event_code = bcld_pkg::EV_LONG_END;
    end
    if (((lockout_next == '0) || pressed) && (phase_next == bcld_pkg::PH_LONG) &&
        event_enable[bcld_pkg::EN_HOLD]) begin
      event_code = bcld_pkg::EV_HOLD;
    end
    // For one to three clicks the count itself is the event code.
    if (confirm_click && click_enabled) begin
      event_code = click_count;
    end
  end

  assign res_new.event_code     = event_code;
  assign res_new.button_pressed = pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bcld_pkg::PH_INACTIVE;
      elapsed     <= '0;
      click_count <= '0;
      long_flag   <= 1'b0;
      lockout     <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      elapsed     <= elapsed_next;
      click_count <= click_count_next;
      long_flag   <= long_flag_next;
      lockout     <= lockout_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid entry
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || report.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || report.ready) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (in_fire) begin
      skid_res <= res_new;
    end
  end

  assign report.valid          = out_valid;
  assign report.event_code     = out_res.event_code;
  assign report.button_pressed = out_res.button_pressed;

endmodule

// ===== sv/bcld_checker.sv =====
// Port-level checks for the button detector, bound to the top level.
// Depends on bcld_pkg and button_click_long_press_detector_assert.svh.
`timescale 1ns / 1ps
`include "button_click_long_press_detector_assert.svh"

module bcld_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_ready,
  input logic                             report_valid,
  input logic                             report_ready,
  input logic [bcld_pkg::EVENT_W-1:0]     report_event_code,
  input logic                             report_pressed
);

  // Only the six defined codes are ever reported.
  `BCLD_ASSERT_SAME(a_code_range, report_valid, report_event_code <= bcld_pkg::EV_LONG_END)

  // Clicks and the end of a long press are reported on a released tick.
  `BCLD_ASSERT_SAME(a_release_events, report_valid && report_event_code != bcld_pkg::EV_NONE && report_event_code != bcld_pkg::EV_HOLD, !report_pressed)

  // A hold is only ever reported while the button is down.
  `BCLD_ASSERT_SAME(a_hold_pressed, report_valid && report_event_code == bcld_pkg::EV_HOLD, report_pressed)

  // With the output stage empty the detector must take samples.
  `BCLD_ASSERT_SAME(a_ready_when_empty, !report_valid, sample_ready)

  `BCLD_ASSERT_NEXT(a_stall_holds, report_valid && !report_ready, report_valid && $stable(report_event_code) && $stable(report_pressed))

endmodule

bind button_click_long_press_detector bcld_checker u_bcld_checker (
  .clk               (clk),
  .rst               (rst),
  .sample_ready      (sample.ready),
  .report_valid      (report.valid),
  .report_ready      (report.ready),
  .report_event_code (report.event_code),
  .report_pressed    (report.button_pressed)
);
